// ----- rtl/core/bisulfite_read_conversion_filter_assert.svh -----
// Assertion macros shared by the checker of the conversion filter
`ifndef BISULFITE_READ_CONVERSION_FILTER_ASSERT_SVH
`define BISULFITE_READ_CONVERSION_FILTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define BRCF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("brcf check failed");

// Next-cycle implication, sampled on clk, off during reset
`define BRCF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("brcf check failed");

`endif

// ----- rtl/core/brcf_pkg.sv -----
// Types, constants and codes of the bisulfite read conversion filter
package brcf_pkg;

  localparam int CNT_W            = 13;
  localparam int CNT_HARD_MAX     = 8191;
  localparam int READ_LEN_MAX_DEF = 4096;
  localparam int NUM_CTX          = 4;
  localparam int LIM_W            = 14;
  localparam int FRAC_W           = 17;
  localparam int FRAC_BITS        = 16;
  localparam int HSUM_W           = CNT_W + 2;  // sum of three counters
  localparam int TOT_W            = CNT_W + 3;  // sum of six counters
  localparam int PROD_W           = FRAC_BITS + TOT_W;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 17;

  // base codes; anything above BASE_T is N
  localparam logic [2:0] BASE_A = 3'd0;
  localparam logic [2:0] BASE_C = 3'd1;
  localparam logic [2:0] BASE_G = 3'd2;
  localparam logic [2:0] BASE_T = 3'd3;

  // counter slots, indexed by the context base
  localparam logic [1:0] CTX_A = 2'd0;
  localparam logic [1:0] CTX_C = 2'd1;
  localparam logic [1:0] CTX_G = 2'd2;
  localparam logic [1:0] CTX_T = 2'd3;

  localparam logic [1:0] STRAND_FWD = 2'd0;
  localparam logic [1:0] STRAND_REV = 2'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_CPH      = 3'd0,
    CFG_MAX_CPA      = 3'd1,
    CFG_MAX_CPC      = 3'd2,
    CFG_MAX_CPT      = 3'd3,
    CFG_MAX_FRACTION = 3'd4,
    CFG_INVERT       = 3'd5
  } brcf_cfg_idx_t;

  typedef struct packed {
    logic [2:0] ref_base;
    logic [2:0] read_base;
    logic [2:0] context_base;
    logic [1:0] strand;
    logic       read_excluded;
    logic       last;
  } brcf_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] cpa_retained;
    logic [CNT_W-1:0] cpa_converted;
    logic [CNT_W-1:0] cpc_retained;
    logic [CNT_W-1:0] cpc_converted;
    logic [CNT_W-1:0] cpg_retained;
    logic [CNT_W-1:0] cpg_converted;
    logic [CNT_W-1:0] cpt_retained;
    logic [CNT_W-1:0] cpt_converted;
    logic             read_failed;
  } brcf_result_t;

  typedef struct packed {
    logic signed [LIM_W-1:0] max_cph;
    logic signed [LIM_W-1:0] max_cpa;
    logic signed [LIM_W-1:0] max_cpc;
    logic signed [LIM_W-1:0] max_cpt;
    logic [FRAC_W-1:0]       max_frac;
    logic                    invert;
  } brcf_cfg_t;

  // read counts at its last item, plus the dropped mark
  typedef struct packed {
    logic                           dropped;
    logic [NUM_CTX-1:0][CNT_W-1:0]  ret;
    logic [NUM_CTX-1:0][CNT_W-1:0]  conv;
  } brcf_snap_t;

  localparam brcf_cfg_t CFG_RESET = '{
    max_cph:  '1,
    max_cpa:  '1,
    max_cpc:  '1,
    max_cpt:  '1,
    max_frac: FRAC_W'(1 << FRAC_BITS),
    invert:   1'b0
  };

endpackage

// ----- rtl/core/brcf_if.sv -----
// Valid/ready channels for input items and result items
interface brcf_item_if;
  logic                valid;
  logic                ready;
  brcf_pkg::brcf_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface brcf_result_if;
  logic                  valid;
  logic                  ready;
  brcf_pkg::brcf_result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/brcf_count.sv -----
// Per-read retention and conversion counters with saturation
module brcf_count #(
  parameter int CNT_CAP = brcf_pkg::READ_LEN_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  brcf_pkg::brcf_item_t item,
  output brcf_pkg::brcf_snap_t snap
);
  import brcf_pkg::*;

  localparam logic [CNT_W-1:0] CAP = CNT_W'(CNT_CAP);

  logic [NUM_CTX-1:0][CNT_W-1:0] ret;
  logic [NUM_CTX-1:0][CNT_W-1:0] conv;
  logic                          dropped;

  logic drop_now;
  logic drop_eff;
  logic fwd;
  logic rev;
  logic hit_ret;
  logic hit_conv;
  logic [CNT_W-1:0] base_r;
  logic [CNT_W-1:0] base_c;

  always_comb begin
    drop_now = item.read_excluded || item.strand[1];
    drop_eff = dropped || drop_now;
    fwd      = (item.strand == STRAND_FWD) && (item.ref_base == BASE_C);
    rev      = (item.strand == STRAND_REV) && (item.ref_base == BASE_G);
    hit_ret  = !drop_eff && !item.context_base[2] &&
               ((fwd && item.read_base == BASE_C) || (rev && item.read_base == BASE_G));
    hit_conv = !drop_eff && !item.context_base[2] &&
               ((fwd && item.read_base == BASE_T) || (rev && item.read_base == BASE_A));
    snap.dropped = drop_eff;
    base_r = '0;
    base_c = '0;
    for (int k = 0; k < NUM_CTX; k++) begin
      base_r = drop_now ? '0 : ret[k];
      base_c = drop_now ? '0 : conv[k];
      snap.ret[k]  = base_r + CNT_W'(hit_ret && (item.context_base[1:0] == 2'(k)) &&
                                     (base_r < CAP));
      snap.conv[k] = base_c + CNT_W'(hit_conv && (item.context_base[1:0] == 2'(k)) &&
                                     (base_c < CAP));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ret     <= '0;
      conv    <= '0;
      dropped <= 1'b0;
    end else if (step) begin
      if (item.last) begin
        ret     <= '0;
        conv    <= '0;
        dropped <= 1'b0;
      end else begin
        ret     <= snap.ret;
        conv    <= snap.conv;
        dropped <= snap.dropped;
      end
    end
  end

endmodule

// ----- rtl/core/brcf_eval.sv -----
// End-of-read limit checks and selection decision
module brcf_eval (
  input  brcf_pkg::brcf_snap_t snap,
  input  brcf_pkg::brcf_cfg_t  cfg,
  output logic                 failed,
  output logic                 emit
);
  import brcf_pkg::*;

  function automatic logic over_limit(input logic [LIM_W-1:0] lim,
                                      input logic [HSUM_W-1:0] val);
    return !lim[LIM_W-1] && (val > HSUM_W'(lim[LIM_W-2:0]));
  endfunction

  logic [HSUM_W-1:0] hr;
  logic [HSUM_W-1:0] hc;
  logic [TOT_W-1:0]  tot;
  logic [PROD_W-1:0] lhs;
  logic [PROD_W-1:0] rhs;
  logic              frac_fail;
  logic              lim_fail;

  always_comb begin
    hr  = HSUM_W'(snap.ret[CTX_A]) + HSUM_W'(snap.ret[CTX_C]) + HSUM_W'(snap.ret[CTX_T]);
    hc  = HSUM_W'(snap.conv[CTX_A]) + HSUM_W'(snap.conv[CTX_C]) +
          HSUM_W'(snap.conv[CTX_T]);
    tot = TOT_W'(hr) + TOT_W'(hc);
    lhs = PROD_W'({hr, FRAC_BITS'(0)});
    rhs = PROD_W'(cfg.max_frac[FRAC_BITS-1:0]) * PROD_W'(tot);
    // top fraction bit set means 1.0 or more: check off
    frac_fail = !cfg.max_frac[FRAC_W-1] && (tot != '0) && (lhs > rhs);
    lim_fail  = over_limit(cfg.max_cpa, HSUM_W'(snap.ret[CTX_A])) ||
                over_limit(cfg.max_cpc, HSUM_W'(snap.ret[CTX_C])) ||
                over_limit(cfg.max_cpt, HSUM_W'(snap.ret[CTX_T])) ||
                over_limit(cfg.max_cph, hr);
    failed = snap.dropped || lim_fail || frac_fail;
    emit   = (failed == cfg.invert);
  end

endmodule

// ----- rtl/core/bisulfite_read_conversion_filter.sv -----
// Top level of the bisulfite read conversion filter
//
//   channel   dir  handshake      payload
//   bases     in   valid/ready    ref/read/context base, strand, excluded, last
//   result    out  valid/ready    eight context counts, read_failed
//   cfg       in   cfg_we         cfg_idx selects register, cfg_data value
//
// One item per cycle when not stalled; three register stages: input register,
// counter update feeding the end-of-read snapshot register, then the limit
// compare (one 16x16 multiply) into the output register.
// After its last item, a result passes the snapshot and output registers.
// rst is synchronous; counters and dropped mark clear, config registers reset.
// A waiting result stalls only the stages behind it; bases.ready drops only
// when an emitting snapshot waits, and items that emit nothing never block.
module bisulfite_read_conversion_filter #(
  parameter int READ_LEN_MAX = brcf_pkg::READ_LEN_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  brcf_item_if.sink                        bases,
  brcf_result_if.source                    result,
  input  logic                             cfg_we,
  input  logic [brcf_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [brcf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import brcf_pkg::*;

  // counters stop at the read length limit, never beyond 13 bits
  localparam int CAP_INT = (READ_LEN_MAX < CNT_HARD_MAX) ? READ_LEN_MAX : CNT_HARD_MAX;

  brcf_cfg_t cfg;

  // stage 1: input register
  logic       s1_valid;
  brcf_item_t s1_item;
  // stage 2: snapshot of a finished read
  logic       s2_valid;
  brcf_snap_t s2_snap;
  brcf_snap_t snap_next;
  // output register
  logic         out_valid;
  brcf_result_t out_data;

  logic s2_failed;
  logic s2_emit;
  logic out_free;
  logic s2_adv;
  logic s1_adv;
  logic s1_fire;

  // ---- configuration registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (brcf_cfg_idx_t'(cfg_idx))
        CFG_MAX_CPH:      cfg.max_cph  <= cfg_data[LIM_W-1:0];
        CFG_MAX_CPA:      cfg.max_cpa  <= cfg_data[LIM_W-1:0];
        CFG_MAX_CPC:      cfg.max_cpc  <= cfg_data[LIM_W-1:0];
        CFG_MAX_CPT:      cfg.max_cpt  <= cfg_data[LIM_W-1:0];
        CFG_MAX_FRACTION: cfg.max_frac <= cfg_data[FRAC_W-1:0];
        CFG_INVERT:       cfg.invert   <= cfg_data[0];
        default: ;  // unlisted index: ignored
      endcase
    end
  end

  // ---- flow control ----
  // A stage moves when the one ahead frees up; a snapshot that emits nothing
  // simply drops out.
  always_comb begin
    out_free = !out_valid || result.ready;
    s2_adv   = !s2_valid || !s2_emit || out_free;
    s1_adv   = !s1_valid || s2_adv;
    s1_fire  = s1_valid && s2_adv;
  end

  assign bases.ready = s1_adv;

  // ---- stage 1 ----
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= bases.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && bases.valid) begin
      s1_item <= bases.data;
    end
  end

  // counters advance as the item leaves stage 1
  brcf_count #(
    .CNT_CAP (CAP_INT)
  ) u_count (
    .clk  (clk),
    .rst  (rst),
    .step (s1_fire),
    .item (s1_item),
    .snap (snap_next)
  );

  // ---- stage 2 ----
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_adv) begin
      s2_valid <= s1_fire && s1_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_item.last) begin
      s2_snap <= snap_next;
    end
  end

  brcf_eval u_eval (
    .snap   (s2_snap),
    .cfg    (cfg),
    .failed (s2_failed),
    .emit   (s2_emit)
  );

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid && s2_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_valid && s2_emit) begin
      out_data.cpa_retained  <= s2_snap.ret[CTX_A];
      out_data.cpa_converted <= s2_snap.conv[CTX_A];
      out_data.cpc_retained  <= s2_snap.ret[CTX_C];
      out_data.cpc_converted <= s2_snap.conv[CTX_C];
      out_data.cpg_retained  <= s2_snap.ret[CTX_G];
      out_data.cpg_converted <= s2_snap.conv[CTX_G];
      out_data.cpt_retained  <= s2_snap.ret[CTX_T];
      out_data.cpt_converted <= s2_snap.conv[CTX_T];
      out_data.read_failed   <= s2_failed;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

endmodule

// ----- rtl/core/brcf_checker.sv -----
// Port-level checker of the conversion filter, bound to the top level
`include "bisulfite_read_conversion_filter_assert.svh"

module brcf_checker #(
  parameter int CNT_CAP = brcf_pkg::READ_LEN_MAX_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_ready,
  input logic                   res_valid,
  input logic                   res_ready,
  input brcf_pkg::brcf_result_t res_data
);
  import brcf_pkg::*;

  localparam logic [CNT_W-1:0] CAP = CNT_W'(CNT_CAP);

  logic cnt_ok;

  assign cnt_ok = (res_data.cpa_retained <= CAP) && (res_data.cpa_converted <= CAP) &&
                  (res_data.cpc_retained <= CAP) && (res_data.cpc_converted <= CAP) &&
                  (res_data.cpg_retained <= CAP) && (res_data.cpg_converted <= CAP) &&
                  (res_data.cpt_retained <= CAP) && (res_data.cpt_converted <= CAP);

  // a stalled result holds
  `BRCF_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_data))
  // input side backs up only behind a stalled result
  `BRCF_ASSERT_NOW(a_ready_stall, !in_ready, res_valid && !res_ready)
  // counts never pass the saturation cap
  `BRCF_ASSERT_NOW(a_cnt_cap, res_valid, cnt_ok)

endmodule

bind bisulfite_read_conversion_filter brcf_checker #(
  .CNT_CAP (CAP_INT)
) u_brcf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (bases.ready),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_data  (result.data)
);
